### hdl/tlbl_pkg.sv
// ----------------------------------------------------------------------------
// tlbl_pkg - shared types and constants for the LRU translation buffer
// Field widths, the request operation codes, controller states and the
// command bundle that passes from the controller to the datapath.
// ----------------------------------------------------------------------------
package tlbl_pkg;

    // Field widths fixed by the request and result formats
    localparam int KEY_W   = 19;
    localparam int FRAME_W = 10;

    // Default number of buffer entries
    localparam int ENTRIES_DEF = 4;

    // Request operation codes
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_FILL   = 1'b1
    } t_op;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;    // apply the current request and load the result
    } t_dp_cmd;

endpackage

### hdl/tlb_lookup_lru_replace_top.sv
// ----------------------------------------------------------------------------
// tlb_lookup_lru_replace_top - fully associative translation buffer, LRU fill
// Request channel: i_valid/o_ready with operation, page key and fill frame.
// Result channel: o_valid/i_ready with hit flag and frame.
//
// A lookup compares the key against all valid entries in parallel; on a hit
// the entry becomes most recently used and its frame is returned. A fill
// overwrites the least recently used entry and makes it most recent; its
// result is always a miss with frame zero.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver takes each result;
// the result register frees up in the same cycle it drains.
// Reset clears all valid bits and sets entry i to rank i; no request is
// pending after reset. When the receiver stalls the result holds in its
// register and o_ready stays low until the result is taken.
// ----------------------------------------------------------------------------
module tlb_lookup_lru_replace_top #(
    parameter int ENTRIES = tlbl_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_operation,
    input  logic [tlbl_pkg::KEY_W-1:0]   i_page_key,
    input  logic [tlbl_pkg::FRAME_W-1:0] i_fill_frame,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit,
    output logic [tlbl_pkg::FRAME_W-1:0] o_frame
);
    import tlbl_pkg::*;

    t_dp_cmd cmd;

    // Handshake controller
    tlbl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // Entry store and LRU datapath
    tlbl_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_operation  (i_operation),
        .i_page_key   (i_page_key),
        .i_fill_frame (i_fill_frame),
        .o_hit        (o_hit),
        .o_frame      (o_frame)
    );

endmodule

### hdl/tlbl_ctrl.sv
// ----------------------------------------------------------------------------
// tlbl_ctrl - request and result handshake controller
// Accepts a request whenever the result register is free or being drained,
// and tells the datapath when to apply it.
// ----------------------------------------------------------------------------
module tlbl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output tlbl_pkg::t_dp_cmd o_cmd
);
    import tlbl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Take a request when no result waits or the waiting one leaves now
    assign o_ready    = (r_state == ST_IDLE) || ((r_state == ST_HOLD) && i_ready);
    assign accept     = i_valid && o_ready;
    assign o_valid    = (r_state == ST_HOLD);
    assign o_cmd.exec = accept;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_ready && !accept) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/tlbl_datapath.sv
// ----------------------------------------------------------------------------
// tlbl_datapath - entry store, parallel compare and LRU rank update
// Holds the entries, matches the key against all of them at once, updates
// ranks on a hit or a fill and registers the result.
// ----------------------------------------------------------------------------
module tlbl_datapath #(
    parameter int ENTRIES = tlbl_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tlbl_pkg::t_dp_cmd            i_cmd,
    input  logic                         i_operation,
    input  logic [tlbl_pkg::KEY_W-1:0]   i_page_key,
    input  logic [tlbl_pkg::FRAME_W-1:0] i_fill_frame,
    output logic                         o_hit,
    output logic [tlbl_pkg::FRAME_W-1:0] o_frame
);
    import tlbl_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(ENTRIES - 1);

    logic                 r_valid [ENTRIES];
    logic [KEY_W-1:0]     r_key   [ENTRIES];
    logic [FRAME_W-1:0]   r_frame [ENTRIES];
    logic [IDX_W-1:0]     r_rank  [ENTRIES];
    logic                 r_hit;
    logic [FRAME_W-1:0]   r_res_frame;

    logic [ENTRIES-1:0]   match;
    logic                 any_hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     old_idx;
    logic [IDX_W-1:0]     hit_rank;
    logic                 is_fill;
    logic                 do_hit;

    // Compare the key with every valid entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_page_key);
        end
    end

    assign any_hit = |match;

    // Pick the lowest matching index and the entry holding rank zero
    always_comb begin
        hit_idx = '0;
        old_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (r_rank[i] == '0) begin
                old_idx = IDX_W'(i);
            end
        end
    end

    assign hit_rank = r_rank[hit_idx];
    assign is_fill  = (i_operation == OP_FILL);
    assign do_hit   = !is_fill && any_hit;

    // Update entries and ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= IDX_W'(i);
            end
        end else if (i_cmd.exec) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (is_fill) begin
                    if (IDX_W'(i) == old_idx) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= TOP_RANK;
                    end else if (r_rank[i] != '0) begin
                        r_rank[i] <= r_rank[i] - 1'b1;
                    end
                end else if (do_hit) begin
                    if (IDX_W'(i) == hit_idx) begin
                        r_rank[i] <= TOP_RANK;
                    end else if (r_rank[i] > hit_rank) begin
                        r_rank[i] <= r_rank[i] - 1'b1;
                    end
                end
            end
        end
    end

    // Write key and frame of the replaced entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && is_fill) begin
            r_key[old_idx]   <= i_page_key;
            r_frame[old_idx] <= i_fill_frame;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_hit       <= do_hit;
            r_res_frame <= do_hit ? r_frame[hit_idx] : '0;
        end
    end

    assign o_hit   = r_hit;
    assign o_frame = r_res_frame;

endmodule

### sim/tb_tlb_lookup_lru_replace_top.sv
// ----------------------------------------------------------------------------
// tb_tlb_lookup_lru_replace_top - regression for the LRU translation buffer
// Lookups and fills go in through the request channel. A shadow copy of the
// buffer (keys, frames, valid bits and LRU ranks) predicts each hit flag and
// frame, and every returned result is compared with the oldest prediction.
// A directed opening covers reset state, extreme keys and frames, eviction
// order and duplicate keys. Random traffic follows over a small key pool.
// Both sides stall at random, with one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module tb_tlb_lookup_lru_replace_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbl_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int RAND_ITEMS  = 500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int KEY_POOL    = 6;

    typedef struct {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_translation;

    // Shadow of the buffer plus the queue of translations still owed
    class tlb_shadow;
        logic               ent_valid [ENTRIES];
        logic [KEY_W-1:0]   ent_key   [ENTRIES];
        logic [FRAME_W-1:0] ent_frame [ENTRIES];
        int unsigned        ent_rank  [ENTRIES];
        t_translation       owed_translations [$];
        int                 mismatches;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                ent_valid[i] = 1'b0;
                ent_key[i]   = '0;
                ent_frame[i] = '0;
                ent_rank[i]  = i;
            end
            mismatches = 0;
        endfunction

        // Apply one accepted request and queue the translation it owes
        function void note_request(t_op op, logic [KEY_W-1:0] key,
                                   logic [FRAME_W-1:0] frm);
            t_translation t;
            int           slot;
            int unsigned  r;
            t.hit   = 1'b0;
            t.frame = '0;
            slot    = -1;
            if (op == OP_LOOKUP) begin
                // lowest-index valid match wins when a key is held twice
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (ent_valid[i] && ent_key[i] == key)
                        slot = i;
                if (slot >= 0) begin
                    r = ent_rank[slot];
                    for (int i = 0; i < ENTRIES; i++)
                        if (ent_rank[i] > r)
                            ent_rank[i]--;
                    ent_rank[slot] = ENTRIES - 1;
                    t.hit   = 1'b1;
                    t.frame = ent_frame[slot];
                end
            end else begin
                // evict the rank-0 entry, no duplicate check
                for (int i = 0; i < ENTRIES; i++)
                    if (ent_rank[i] == 0)
                        slot = i;
                for (int i = 0; i < ENTRIES; i++)
                    if (i != slot && ent_rank[i] > 0)
                        ent_rank[i]--;
                ent_valid[slot] = 1'b1;
                ent_key[slot]   = key;
                ent_frame[slot] = frm;
                ent_rank[slot]  = ENTRIES - 1;
            end
            owed_translations.push_back(t);
        endfunction

        // Compare one accepted result with the oldest owed translation
        function void check_result(logic hit, logic [FRAME_W-1:0] frm);
            t_translation t;
            if (owed_translations.size() == 0) begin
                $display("%0t: unexpected result hit=%b frame=%0d", $time, hit, frm);
                mismatches++;
                return;
            end
            t = owed_translations.pop_front();
            if (hit !== t.hit) begin
                $display("%0t: hit expected %b actual %b", $time, t.hit, hit);
                mismatches++;
            end
            if (frm !== t.frame) begin
                $display("%0t: frame expected %0d actual %0d", $time, t.frame, frm);
                mismatches++;
            end
        endfunction

        function int owed_count();
            return owed_translations.size();
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_ready;
    logic               i_operation  = 1'b0;
    logic [KEY_W-1:0]   i_page_key   = '0;
    logic [FRAME_W-1:0] i_fill_frame = '0;
    logic               o_valid;
    logic               i_ready      = 1'b0;
    logic               o_hit;
    logic [FRAME_W-1:0] o_frame;

    tlb_shadow          board = new();
    bit                 steady = 1'b0;
    int                 cycle_count = 0;
    logic [KEY_W-1:0]   key_pool [KEY_POOL];

    tlb_lookup_lru_replace_top #(
        .ENTRIES (ENTRIES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_page_key   (i_page_key),
        .i_fill_frame (i_fill_frame),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit),
        .o_frame      (o_frame)
    );

    always #6 i_clk = ~i_clk;

    // Drain results and pick the next stall decision
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                board.check_result(o_hit, o_frame);
            i_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 34);
        end
    end

    // Abort on a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tlb_lookup_lru_replace_top regression: fail");
        $finish;
    end

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input t_op op, input logic [KEY_W-1:0] key,
                                input logic [FRAME_W-1:0] frm);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 34)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_page_key   <= key;
        i_fill_frame <= frm;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(op, key, frm);
    endtask

    // Hold off new requests until every owed result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (board.owed_count() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return KEY_W'($urandom);
    endfunction

    initial begin
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] key_c;
        t_op              op;

        key_a = 19'h2A5C3;
        key_b = 19'h15A3C;
        key_c = 19'h40001;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = KEY_W'($urandom);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no entry is valid after reset, so lookups before any fill must not hit
        send_request(OP_LOOKUP, '0, '0);
        send_request(OP_LOOKUP, '1, '1);
        // fill the buffer with extreme keys and frames
        send_request(OP_FILL, '0, '1);
        send_request(OP_FILL, '1, '0);
        send_request(OP_FILL, key_a, 10'h155);
        send_request(OP_FILL, key_b, 10'h2AA);
        send_request(OP_LOOKUP, '0, 10'h3C3);
        send_request(OP_LOOKUP, '1, '0);
        // key_a is now least recent: fill evicts it
        send_request(OP_FILL, key_c, 10'h001);
        send_request(OP_LOOKUP, key_a, '0);
        send_request(OP_LOOKUP, key_c, '1);
        // fill a key already present: the first fill evicts the entry holding it, the second leaves it held twice
        send_request(OP_FILL, key_b, 10'h3FE);
        send_request(OP_LOOKUP, key_b, '0);
        send_request(OP_FILL, key_b, 10'h200);
        send_request(OP_LOOKUP, key_b, '1);
        // miss leaves ranks alone; next fill follows prior order
        send_request(OP_LOOKUP, 19'h7FFFE, '0);
        send_request(OP_FILL, 19'h00001, 10'h3FF);
        send_request(OP_LOOKUP, 19'h00001, '0);
        send_request(OP_LOOKUP, '0, '0);
        drain_results();

        // random traffic over a small key pool so hits are common
        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 200 && n < 320);
            if ($urandom_range(0, 99) < 10)
                key_pool[$urandom_range(0, KEY_POOL - 1)] = KEY_W'($urandom);
            op = ($urandom_range(0, 99) < 30) ? OP_FILL : OP_LOOKUP;
            send_request(op, pick_key(op == OP_FILL ? 70 : 75), FRAME_W'($urandom));
            if (n == 350)
                drain_results();
        end
        steady = 1'b0;

        // let the last results come home, then report
        drain_results();
        repeat (4) @(posedge i_clk);
        if (board.mismatches == 0 && board.owed_count() == 0) begin
            $display("tlb_lookup_lru_replace_top regression: pass");
        end else begin
            $display("tlb_lookup_lru_replace_top regression: fail");
        end
        $finish;
    end

endmodule

### files.f
hdl/tlbl_pkg.sv
hdl/tlbl_ctrl.sv
hdl/tlbl_datapath.sv
hdl/tlb_lookup_lru_replace_top.sv
sim/tb_tlb_lookup_lru_replace_top.sv
